// ===== hdl/nonzero_pixel_bounding_box_assert.svh =====
// Assertion macros used by the bounding box top level.
`ifndef NONZERO_PIXEL_BOUNDING_BOX_ASSERT_SVH
`define NONZERO_PIXEL_BOUNDING_BOX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPBB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NPBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/npbb_pkg.sv =====
// Package with constants, types and helper functions for the bounding box block.
`timescale 1ns / 1ps
package npbb_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int MAX_CHANNELS  = 4;
   localparam int INPUT_FIELDS  = 4;
   localparam int SAMPLE_BITS   = 32;
   localparam int DIM_W         = 13;
   localparam int COORD_W       = 12;
   localparam int CHAN_W        = 3;
   localparam int MODE_W        = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 13;
   localparam int EXT_W         = DIM_W + 1;

   localparam int MODE_ALPHA   = 0;
   localparam int MODE_FLOAT   = 1;
   localparam int MODE_PROTECT = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH    = 3'd0,
      REG_FRAME_HEIGHT   = 3'd1,
      REG_CHANNEL_COUNT  = 3'd2,
      REG_MODE_FLAGS     = 3'd3,
      REG_PROTECT_LEFT   = 3'd4,
      REG_PROTECT_TOP    = 3'd5,
      REG_PROTECT_SPAN_X = 3'd6,
      REG_PROTECT_SPAN_Y = 3'd7
   } csr_index_type;

   typedef logic [INPUT_FIELDS-1:0][SAMPLE_BITS-1:0] pixel_type;

   // Extent of the non-empty pixels of one frame.
   typedef struct packed {
      logic             any;
      logic [DIM_W-1:0] min_col;
      logic [DIM_W-1:0] min_row;
      logic [DIM_W-1:0] end_col;
      logic [DIM_W-1:0] end_row;
   } box_acc_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic               status;
   } box_result_type;

   // Zero acts as one and anything past the maximum acts as the maximum.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIMENSION)) begin
         r = DIM_W'(MAX_DIMENSION);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== hdl/npbb_pixel_test.sv =====
// Decides whether one pixel holds a non-zero checked sample.
`timescale 1ns / 1ps
module npbb_pixel_test (
   input  npbb_pkg::pixel_type             samples,
   input  logic [npbb_pkg::CHAN_W-1:0]     channel_count,
   input  logic [npbb_pkg::MODE_W-1:0]     mode_flags,
   output logic                            hit
);
   import npbb_pkg::*;

   logic [CHAN_W-1:0]      chan_n;
   logic [CHAN_W-1:0]      chan_first;
   logic [SAMPLE_BITS-1:0] sample_mask;

   always_comb begin
      if (channel_count == '0) begin
         chan_n = CHAN_W'(1);
      end else if (channel_count > CHAN_W'(MAX_CHANNELS)) begin
         chan_n = CHAN_W'(MAX_CHANNELS);
      end else begin
         chan_n = channel_count;
      end
      if (chan_n > CHAN_W'(INPUT_FIELDS)) begin
         chan_n = CHAN_W'(INPUT_FIELDS);
      end
      chan_first = mode_flags[MODE_ALPHA] ? chan_n - CHAN_W'(1) : '0;
   end

   // Float samples drop the sign bit so that negative zero counts as empty.
   always_comb begin
      sample_mask = '1;
      if (mode_flags[MODE_FLOAT]) begin
         sample_mask[SAMPLE_BITS-1] = 1'b0;
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int c = 0; c < INPUT_FIELDS; c++) begin
         if (CHAN_W'(c) >= chan_first && CHAN_W'(c) < chan_n &&
             (samples[c] & sample_mask) != '0) begin
            hit = 1'b1;
         end
      end
   end

endmodule

// ===== hdl/npbb_result.sv =====
// Forms the crop region and status of a finished frame.
`timescale 1ns / 1ps
module npbb_result (
   input  npbb_pkg::box_acc_type           acc,
   input  logic [npbb_pkg::DIM_W-1:0]      width_eff,
   input  logic [npbb_pkg::DIM_W-1:0]      height_eff,
   input  logic                            protect_en,
   input  logic [npbb_pkg::DIM_W-1:0]      protect_left,
   input  logic [npbb_pkg::DIM_W-1:0]      protect_top,
   input  logic [npbb_pkg::DIM_W-1:0]      protect_span_x,
   input  logic [npbb_pkg::DIM_W-1:0]      protect_span_y,
   output npbb_pkg::box_result_type        result
);
   import npbb_pkg::*;

   logic             fits;
   logic [EXT_W-1:0] prot_lx, prot_ly, prot_ex, prot_ey;
   logic [EXT_W-1:0] acc_lx, acc_ly, acc_ex, acc_ey;
   logic [EXT_W-1:0] lx, ly, ex, ey;
   logic [EXT_W-1:0] span_w, span_h;
   logic             status;

   // When a span already exceeds the frame the wrapped difference is never decisive.
   assign fits = !(protect_span_x > width_eff ||
                   protect_left > width_eff - protect_span_x ||
                   protect_span_y > height_eff ||
                   protect_top > height_eff - protect_span_y);

   assign prot_lx = EXT_W'(protect_left);
   assign prot_ly = EXT_W'(protect_top);
   assign prot_ex = EXT_W'(protect_left) + EXT_W'(protect_span_x);
   assign prot_ey = EXT_W'(protect_top) + EXT_W'(protect_span_y);
   assign acc_lx  = EXT_W'(acc.min_col);
   assign acc_ly  = EXT_W'(acc.min_row);
   assign acc_ex  = EXT_W'(acc.end_col);
   assign acc_ey  = EXT_W'(acc.end_row);

   always_comb begin
      lx     = '0;
      ly     = '0;
      ex     = '0;
      ey     = '0;
      status = 1'b0;
      if (protect_en) begin
         if (!fits) begin
            status = 1'b1;
         end else if (acc.any) begin
            lx = (acc_lx < prot_lx) ? acc_lx : prot_lx;
            ly = (acc_ly < prot_ly) ? acc_ly : prot_ly;
            ex = (acc_ex > prot_ex) ? acc_ex : prot_ex;
            ey = (acc_ey > prot_ey) ? acc_ey : prot_ey;
         end else if (protect_span_x != '0 && protect_span_y != '0) begin
            lx = prot_lx;
            ly = prot_ly;
            ex = prot_ex;
            ey = prot_ey;
         end
      end else if (acc.any) begin
         lx = acc_lx;
         ly = acc_ly;
         ex = acc_ex;
         ey = acc_ey;
      end
      if (ex <= lx || ey <= ly) begin
         lx = '0;
         ly = '0;
         ex = '0;
         ey = '0;
      end
   end

   assign span_w = ex - lx;
   assign span_h = ey - ly;

   assign result.left   = lx[COORD_W-1:0];
   assign result.top    = ly[COORD_W-1:0];
   assign result.width  = span_w[DIM_W-1:0];
   assign result.height = span_h[DIM_W-1:0];
   assign result.status = status;

endmodule

// ===== hdl/nonzero_pixel_bounding_box.sv =====
// Top level of the bounding box finder for non-empty pixels of a raster frame.
// Pixels enter on the req_ channel in raster order, one transaction per pixel,
// carrying up to four channel samples. The block counts column and row itself
// from the frame size set through the csr_ write port.
// A pixel counts as non-empty when a checked sample is non-zero; the smallest
// and largest hit coordinates are kept, and an optional protect region is
// merged in when the frame ends.
// One rsp_ transaction follows the last pixel of each frame and carries the
// crop region and a status bit; other pixels produce no result.
// Throughput is one pixel per cycle unless a last pixel waits for the snapshot
// register; the position counters and the extent registers update per pixel.
// After the last pixel is accepted, the result passes through the input register
// and the frame snapshot register before it is loaded into the output register.
// A stalled receiver holds the result; the next frame keeps streaming until
// its own last pixel finds the snapshot register still occupied.
// Synchronous reset clears the counters, the extents and all valid flags and
// loads the register defaults.
`timescale 1ns / 1ps
module nonzero_pixel_bounding_box (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [npbb_pkg::SAMPLE_BITS-1:0]    req_sample_ch0,
   input  logic [npbb_pkg::SAMPLE_BITS-1:0]    req_sample_ch1,
   input  logic [npbb_pkg::SAMPLE_BITS-1:0]    req_sample_ch2,
   input  logic [npbb_pkg::SAMPLE_BITS-1:0]    req_sample_ch3,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [npbb_pkg::COORD_W-1:0]        rsp_box_left,
   output logic [npbb_pkg::COORD_W-1:0]        rsp_box_top,
   output logic [npbb_pkg::DIM_W-1:0]          rsp_box_width,
   output logic [npbb_pkg::DIM_W-1:0]          rsp_box_height,
   output logic                                rsp_status,
   input  logic                                csr_we,
   input  logic [npbb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [npbb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import npbb_pkg::*;
`include "nonzero_pixel_bounding_box_assert.svh"

   // Configuration registers.
   logic [DIM_W-1:0]  frame_width_ff, frame_height_ff;
   logic [CHAN_W-1:0] channel_count_ff;
   logic [MODE_W-1:0] mode_flags_ff;
   logic [DIM_W-1:0]  protect_left_ff, protect_top_ff;
   logic [DIM_W-1:0]  protect_span_x_ff, protect_span_y_ff;

   // Input register.
   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_pixel_ff;

   // Position and extent of the frame in progress.
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   box_acc_type        acc_ff, acc_in, acc_upd;

   // Snapshot of a finished frame.
   logic        fin_valid_ff, fin_valid_in;
   box_acc_type fin_ff;

   // Output register.
   logic           rsp_valid_ff, rsp_valid_in;
   box_result_type rsp_ff, result;

   logic [DIM_W-1:0] width_eff, height_eff;
   logic [DIM_W-1:0] col_ext, row_ext, col_next, row_next;
   logic             hit, col_last, row_last, frame_last;
   logic             out_load, fin_free, s1_consume, req_take;

   assign width_eff  = eff_dim(frame_width_ff);
   assign height_eff = eff_dim(frame_height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= DIM_W'(1);
         frame_height_ff   <= DIM_W'(1);
         channel_count_ff  <= CHAN_W'(1);
         mode_flags_ff     <= '0;
         protect_left_ff   <= '0;
         protect_top_ff    <= '0;
         protect_span_x_ff <= '0;
         protect_span_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_FRAME_WIDTH:    frame_width_ff    <= csr_wdata;
            REG_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata;
            REG_CHANNEL_COUNT:  channel_count_ff  <= csr_wdata[CHAN_W-1:0];
            REG_MODE_FLAGS:     mode_flags_ff     <= csr_wdata[MODE_W-1:0];
            REG_PROTECT_LEFT:   protect_left_ff   <= csr_wdata;
            REG_PROTECT_TOP:    protect_top_ff    <= csr_wdata;
            REG_PROTECT_SPAN_X: protect_span_x_ff <= csr_wdata;
            REG_PROTECT_SPAN_Y: protect_span_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   npbb_pixel_test u_pixel_test (
      .samples       (s1_pixel_ff),
      .channel_count (channel_count_ff),
      .mode_flags    (mode_flags_ff),
      .hit           (hit)
   );

   // Handshake chain: output register, snapshot register, input register.
   assign out_load   = fin_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign fin_free   = !fin_valid_ff || out_load;
   assign s1_consume = s1_valid_ff && (!frame_last || fin_free);
   assign req_ready  = !s1_valid_ff || s1_consume;
   assign req_take   = req_valid && req_ready;

   assign s1_valid_in = req_take ? 1'b1 : (s1_consume ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pixel_ff <= {req_sample_ch3, req_sample_ch2, req_sample_ch1, req_sample_ch0};
      end
   end

   // A row ends once the next column reaches or passes the current width.
   assign col_ext    = DIM_W'(col_ff);
   assign row_ext    = DIM_W'(row_ff);
   assign col_next   = col_ext + DIM_W'(1);
   assign row_next   = row_ext + DIM_W'(1);
   assign col_last   = col_next >= width_eff;
   assign row_last   = row_next >= height_eff;
   assign frame_last = col_last && row_last;

   always_comb begin
      acc_upd = acc_ff;
      if (hit) begin
         acc_upd.any = 1'b1;
         if (col_ext < acc_ff.min_col) begin
            acc_upd.min_col = col_ext;
         end
         if (row_ext < acc_ff.min_row) begin
            acc_upd.min_row = row_ext;
         end
         if (col_next > acc_ff.end_col) begin
            acc_upd.end_col = col_next;
         end
         if (row_next > acc_ff.end_row) begin
            acc_upd.end_row = row_next;
         end
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      acc_in = acc_ff;
      if (s1_consume) begin
         if (frame_last) begin
            col_in = '0;
            row_in = '0;
            acc_in = '{any: 1'b0, min_col: '1, min_row: '1, end_col: '0, end_row: '0};
         end else if (col_last) begin
            col_in = '0;
            row_in = row_next[COORD_W-1:0];
            acc_in = acc_upd;
         end else begin
            col_in = col_next[COORD_W-1:0];
            acc_in = acc_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         acc_ff <= '{any: 1'b0, min_col: '1, min_row: '1, end_col: '0, end_row: '0};
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         acc_ff <= acc_in;
      end
   end

   assign fin_valid_in = (s1_consume && frame_last) ? 1'b1 :
                         (out_load ? 1'b0 : fin_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_consume && frame_last) begin
         fin_ff <= acc_upd;
      end
   end

   npbb_result u_result (
      .acc            (fin_ff),
      .width_eff      (width_eff),
      .height_eff     (height_eff),
      .protect_en     (mode_flags_ff[MODE_PROTECT]),
      .protect_left   (protect_left_ff),
      .protect_top    (protect_top_ff),
      .protect_span_x (protect_span_x_ff),
      .protect_span_y (protect_span_y_ff),
      .result         (result)
   );

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_box_left   = rsp_ff.left;
   assign rsp_box_top    = rsp_ff.top;
   assign rsp_box_width  = rsp_ff.width;
   assign rsp_box_height = rsp_ff.height;
   assign rsp_status     = rsp_ff.status;

   // A frame with hits always has a non-empty extent.
   `NPBB_ASSERT_NOW(a_extent_ordered, clock, reset, acc_ff.any,
      acc_ff.min_col < acc_ff.end_col && acc_ff.min_row < acc_ff.end_row)
   // Without hits min_col, end_col and end_row still hold their cleared values.
   `NPBB_ASSERT_NOW(a_extent_cleared, clock, reset, !acc_ff.any,
      acc_ff.min_col == '1 && acc_ff.end_col == '0 && acc_ff.end_row == '0)
   // A waiting snapshot is never dropped before it reaches the output register.
   `NPBB_ASSERT_NEXT(a_snapshot_kept, clock, reset, fin_valid_ff && !out_load,
      fin_valid_ff)
   // An error status always comes with an all-zero region.
   `NPBB_ASSERT_NOW(a_error_zero_box, clock, reset, rsp_valid_ff && rsp_ff.status,
      rsp_ff.left == '0 && rsp_ff.top == '0 && rsp_ff.width == '0 && rsp_ff.height == '0)

endmodule
